### rtl/bps_pkg.sv
// Shared types, constants and tables for the ballistic pitch solver.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bps_pkg;

   // Field and datapath widths.
   localparam int POS_W         = 24;
   localparam int SPEED_W       = 16;
   localparam int ANGLE_W       = 18;
   localparam int RAD_W         = 48;
   localparam int TERM_W        = 59;
   localparam int SQ_RAD_W      = 58;
   localparam int SQ_ROOT_W     = 29;
   localparam int CORDIC_STAGES = 20;
   localparam int CSR_INDEX_W   = 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 2'd2;

   // Register reset values.
   localparam logic [SPEED_W-1:0] SPEED_RESET   = 16'd3840;
   localparam logic [SPEED_W-1:0] GRAVITY_RESET = 16'd2511;

   // Output angle constants in Q2.16 radians and table-mode constants.
   localparam logic signed [33:0] PITCH_HALF_PI    = 34'sd102944;
   localparam logic [ANGLE_W-1:0] PITCH_QUARTER_PI = 18'd51472;
   localparam logic [24:0]        RAD_PER_DEG_Q30  = 25'd18740330;
   localparam logic [POS_W-1:0]   DIST_LO          = 24'd327680;
   localparam logic [POS_W-1:0]   DIST_HI          = 24'd983040;

   typedef enum logic [1:0] {
      STATUS_SOLVED   = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_VERTICAL = 2'd2
   } status_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [SPEED_W-1:0] gravity;
      logic               analytic;
   } cfg_type;

   // One classified transaction handed from the front to the back.
   typedef struct packed {
      logic [RAD_W-1:0]         rad;
      logic signed [TERM_W-1:0] term;
      logic [31:0]              v2;
      logic [SPEED_W-1:0]       gravity;
      logic                     y_le0;
      logic                     analytic;
   } entry_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic logic signed [32:0] atan_q30(input int idx);
      case (idx)
         0:  return 33'sd843314857;
         1:  return 33'sd497837829;
         2:  return 33'sd263043837;
         3:  return 33'sd133525159;
         4:  return 33'sd67021687;
         5:  return 33'sd33543516;
         6:  return 33'sd16775851;
         7:  return 33'sd8388437;
         8:  return 33'sd4194283;
         9:  return 33'sd2097149;
         10: return 33'sd1048576;
         11: return 33'sd524288;
         12: return 33'sd262144;
         13: return 33'sd131072;
         14: return 33'sd65536;
         15: return 33'sd32768;
         16: return 33'sd16384;
         17: return 33'sd8192;
         18: return 33'sd4096;
         19: return 33'sd2048;
         20: return 33'sd1024;
         21: return 33'sd512;
         22: return 33'sd256;
         23: return 33'sd128;
         24: return 33'sd64;
         25: return 33'sd32;
         26: return 33'sd16;
         27: return 33'sd8;
         28: return 33'sd4;
         29: return 33'sd2;
         30: return 33'sd1;
         default: return 33'sd0;
      endcase
   endfunction

endpackage

`default_nettype wire

### rtl/bps_if.sv
// Handshake channel interfaces: target requests, pitch responses, register writes.
// Depends on bps_pkg for field widths.
`default_nettype none

interface bps_req_if;
   import bps_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] target_x;
   logic signed [POS_W-1:0] target_y;
   logic signed [POS_W-1:0] target_z;
   modport source (output valid, target_x, target_y, target_z, input ready);
   modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface bps_rsp_if;
   import bps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] elev_angle;
   logic [1:0]                solve_status;
   modport source (output valid, elev_angle, solve_status, input ready);
   modport sink (input valid, elev_angle, solve_status, output ready);
endinterface

interface bps_csr_if;
   import bps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [SPEED_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/ballistic_pitch_solver.sv
// Top level of the ballistic pitch solver: register file and the front, queue, back.
// Depends on bps_pkg, bps_if, bps_front, bps_queue and bps_back.
`default_nettype none

// The solver takes one target transaction per clock while the front is not held by a
// full queue, and returns one pitch transaction for each, in order. A target passes
// five front stages, the queue, 29 square-root stages, one assembly stage, 20 CORDIC
// stages and the result register; the rate of one transaction per cycle is set by
// the fully pipelined square-root and CORDIC stages. The four
// entry queue lets the front keep accepting while the result side is stalled.
// Registers are written through the csr channel, which is always ready, and must
// only be changed while no transaction is in flight. No clearing pass follows reset.
module ballistic_pitch_solver (
   input  logic    clock,
   input  logic    reset,
   bps_req_if.sink   req_chan,
   bps_rsp_if.source rsp_chan,
   bps_csr_if.sink   csr_chan
);
   import bps_pkg::*;

   logic [SPEED_W-1:0] speed_ff, gravity_ff;
   logic               mode_ff;
   cfg_type            cfg;

   assign csr_chan.ready = 1'b1;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= SPEED_RESET;
         gravity_ff <= GRAVITY_RESET;
         mode_ff    <= 1'b1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SPEED:   speed_ff   <= csr_chan.data;
            CSR_GRAVITY: gravity_ff <= csr_chan.data;
            CSR_MODE:    mode_ff    <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   assign cfg.speed    = speed_ff;
   assign cfg.gravity  = gravity_ff;
   assign cfg.analytic = mode_ff;

   logic      q_full, q_push, q_pop, q_nonempty;
   entry_type q_data, q_head;

   bps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   bps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .nonempty  (q_nonempty)
   );

   bps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_nonempty (q_nonempty),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/bps_front.sv
// Front pipeline: takes targets, forms squares and the discriminant terms.
// Depends on bps_pkg and bps_if; feeds bps_queue.
`default_nettype none

module bps_front (
   input  logic                clock,
   input  logic                reset,
   bps_req_if.sink             req_chan,
   input  bps_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                q_push,
   output bps_pkg::entry_type  q_data
);
   import bps_pkg::*;

   logic [4:0] stage_v_ff;
   logic       adv;

   // The front holds while its last stage cannot enter the queue.
   assign adv            = !(stage_v_ff[4] && q_full);
   assign req_chan.ready = adv;
   assign q_push         = stage_v_ff[4] && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else if (adv) begin
         stage_v_ff <= {stage_v_ff[3:0], req_chan.valid};
      end
   end

   // Stage 1: magnitudes and register snapshot.
   logic [POS_W-1:0]   mx1_ff, my1_ff, mz1_ff;
   logic               yneg1_ff, yle01_ff, mode1_ff;
   logic [SPEED_W-1:0] v1_ff, g1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx1_ff   <= req_chan.target_x[POS_W-1] ? POS_W'(-req_chan.target_x) : req_chan.target_x;
         my1_ff   <= req_chan.target_y[POS_W-1] ? POS_W'(-req_chan.target_y) : req_chan.target_y;
         mz1_ff   <= req_chan.target_z[POS_W-1] ? POS_W'(-req_chan.target_z) : req_chan.target_z;
         yneg1_ff <= req_chan.target_y[POS_W-1];
         yle01_ff <= req_chan.target_y[POS_W-1] || (req_chan.target_y == '0);
         mode1_ff <= cfg.analytic;
         v1_ff    <= cfg.speed;
         g1_ff    <= cfg.gravity;
      end
   end

   // Stage 2: coordinate squares and speed squared.
   logic [RAD_W-1:0]   x2_ff, y2_ff, z2_ff;
   logic [31:0]        v2_2_ff;
   logic [POS_W-1:0]   my2_ff;
   logic               yneg2_ff, yle02_ff, mode2_ff;
   logic [SPEED_W-1:0] g2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff    <= mx1_ff * mx1_ff;
         y2_ff    <= my1_ff * my1_ff;
         z2_ff    <= mz1_ff * mz1_ff;
         v2_2_ff  <= v1_ff * v1_ff;
         my2_ff   <= my1_ff;
         yneg2_ff <= yneg1_ff;
         yle02_ff <= yle01_ff;
         mode2_ff <= mode1_ff;
         g2_ff    <= g1_ff;
      end
   end

   // Stage 3: horizontal and (table mode) full radicands, v^4 and |y|*v^2.
   logic [63:0] v4_full;
   logic [55:0] myv_full;
   logic [RAD_W-1:0] hsq2;

   assign v4_full  = v2_2_ff * v2_2_ff;
   assign myv_full = my2_ff * v2_2_ff;
   assign hsq2     = x2_ff + z2_ff;

   logic [RAD_W-1:0]   hsq3_ff, rad3_ff;
   logic [55:0]        v4_3_ff;
   logic [38:0]        myv3_ff;
   logic [31:0]        v2_3_ff;
   logic               yneg3_ff, yle03_ff, mode3_ff;
   logic [SPEED_W-1:0] g3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hsq3_ff  <= hsq2;
         rad3_ff  <= mode2_ff ? hsq2 : hsq2 + y2_ff;
         v4_3_ff  <= v4_full[63:8];
         myv3_ff  <= myv_full[54:16];
         v2_3_ff  <= v2_2_ff;
         yneg3_ff <= yneg2_ff;
         yle03_ff <= yle02_ff;
         mode3_ff <= mode2_ff;
         g3_ff    <= g2_ff;
      end
   end

   // Stage 4: first gravity products.
   logic [63:0] gh_full;
   logic [54:0] gyv_full;

   assign gh_full  = g3_ff * hsq3_ff;
   assign gyv_full = myv3_ff * g3_ff;

   logic [38:0]        gh4_ff;
   logic [55:0]        gyv4_ff, v4_4_ff;
   logic [RAD_W-1:0]   rad4_ff;
   logic [31:0]        v2_4_ff;
   logic               yneg4_ff, yle04_ff, mode4_ff;
   logic [SPEED_W-1:0] g4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gh4_ff   <= gh_full[62:24];
         gyv4_ff  <= {gyv_full, 1'b0};
         v4_4_ff  <= v4_3_ff;
         rad4_ff  <= rad3_ff;
         v2_4_ff  <= v2_3_ff;
         yneg4_ff <= yneg3_ff;
         yle04_ff <= yle03_ff;
         mode4_ff <= mode3_ff;
         g4_ff    <= g3_ff;
      end
   end

   // Stage 5: second gravity product on the horizontal term.
   logic [54:0]        ggh5_ff;
   logic [55:0]        gyv5_ff, v4_5_ff;
   logic [RAD_W-1:0]   rad5_ff;
   logic [31:0]        v2_5_ff;
   logic               yneg5_ff, yle05_ff, mode5_ff;
   logic [SPEED_W-1:0] g5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ggh5_ff  <= gh4_ff * g4_ff;
         gyv5_ff  <= gyv4_ff;
         v4_5_ff  <= v4_4_ff;
         rad5_ff  <= rad4_ff;
         v2_5_ff  <= v2_4_ff;
         yneg5_ff <= yneg4_ff;
         yle05_ff <= yle04_ff;
         mode5_ff <= mode4_ff;
         g5_ff    <= g4_ff;
      end
   end

   // Discriminant assembly feeds the queue directly.
   logic signed [TERM_W-1:0] base_term;
   logic signed [TERM_W-1:0] gyv_term;

   assign base_term = $signed(TERM_W'(v4_5_ff)) - $signed(TERM_W'(ggh5_ff));
   assign gyv_term  = $signed(TERM_W'(gyv5_ff));

   always_comb begin
      q_data          = '0;
      q_data.rad      = rad5_ff;
      q_data.term     = yneg5_ff ? base_term - gyv_term : base_term + gyv_term;
      q_data.v2       = v2_5_ff;
      q_data.gravity  = g5_ff;
      q_data.y_le0    = yle05_ff;
      q_data.analytic = mode5_ff;
   end

endmodule

`default_nettype wire

### rtl/bps_queue.sv
// Short flop queue that decouples the front from the back.
// Depends on bps_pkg for the entry type and depth.
`default_nettype none

module bps_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bps_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output bps_pkg::entry_type  head,
   output logic                nonempty
);
   import bps_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];

   // Pointer and fill tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/bps_sqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on bps_pkg for the radicand and root widths.
`default_nettype none

module bps_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [bps_pkg::SQ_RAD_W-1:0]  rad_in,
   output logic [bps_pkg::SQ_ROOT_W-1:0] root_out
);
   import bps_pkg::*;

   logic [SQ_RAD_W-1:0]  rem_ff  [SQ_ROOT_W];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_ROOT_W];

   // Each stage settles one root bit, highest first, on the running remainder.
   for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_stage
      localparam int BIT = SQ_ROOT_W - 1 - k;
      logic [SQ_RAD_W-1:0]  rem_prev;
      logic [SQ_ROOT_W-1:0] root_prev;
      logic [59:0]          trial;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_prev  = rad_in;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign trial = ({31'b0, root_prev} << (BIT + 1)) + (60'd1 << (2 * BIT));
      assign take  = ({2'b0, rem_prev} >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_prev - trial[SQ_RAD_W-1:0] : rem_prev;
            root_ff[k] <= take ? (root_prev | (SQ_ROOT_W'(1) << BIT)) : root_prev;
         end
      end
   end

   assign root_out = root_ff[SQ_ROOT_W-1];

endmodule

`default_nettype wire

### rtl/bps_back.sv
// Back pipeline: square roots, CORDIC arctangent, table product and result register.
// Depends on bps_pkg, bps_if and bps_sqrt; drains bps_queue.
`default_nettype none

module bps_back (
   input  logic                clock,
   input  logic                reset,
   input  bps_pkg::entry_type  q_head,
   input  logic                q_nonempty,
   output logic                q_pop,
   bps_rsp_if.source           rsp_chan
);
   import bps_pkg::*;

   typedef struct packed {
      logic               term_neg;
      logic               y_le0;
      logic               analytic;
      logic [SPEED_W-1:0] gravity;
      logic [31:0]        v2;
   } side_type;

   typedef struct packed {
      logic        term_neg;
      logic        y_le0;
      logic        analytic;
      logic        den_zero;
      logic [48:0] tprod;
   } flag_type;

   logic en;
   logic out_v_ff;

   // The whole back advances whenever the result register is free or draining.
   assign en    = !out_v_ff || rsp_chan.ready;
   assign q_pop = en && q_nonempty;

   // Square roots of the distance radicand and of the discriminant.
   logic [SQ_ROOT_W-1:0] h_root, s_root;

   bps_sqrt u_sqrt_h (
      .clock    (clock),
      .en       (en),
      .rad_in   ({10'b0, q_head.rad}),
      .root_out (h_root)
   );

   bps_sqrt u_sqrt_s (
      .clock    (clock),
      .en       (en),
      .rad_in   (q_head.term[TERM_W-1] ? '0 : q_head.term[SQ_RAD_W-1:0]),
      .root_out (s_root)
   );

   // Side information travels alongside the root stages.
   side_type             side_ff [SQ_ROOT_W];
   logic [SQ_ROOT_W-1:0] side_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
      end else if (en) begin
         side_v_ff <= {side_v_ff[SQ_ROOT_W-2:0], q_nonempty};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].term_neg <= q_head.term[TERM_W-1];
         side_ff[0].y_le0    <= q_head.y_le0;
         side_ff[0].analytic <= q_head.analytic;
         side_ff[0].gravity  <= q_head.gravity;
         side_ff[0].v2       <= q_head.v2;
         for (int k = 1; k < SQ_ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Denominator, numerator and table product from the roots.
   side_type         side_last;
   logic [POS_W-1:0] h_val;
   logic [POS_W-1:0] dist_c;
   logic [39:0]      den;
   logic signed [41:0] num;

   assign side_last = side_ff[SQ_ROOT_W-1];
   assign h_val     = h_root[POS_W-1:0];
   assign dist_c    = (h_val < DIST_LO) ? DIST_LO : ((h_val > DIST_HI) ? DIST_HI : h_val);
   assign den       = side_last.gravity * h_val;
   assign num       = $signed({2'b0, side_last.v2, 8'b0}) - $signed({1'b0, s_root, 12'b0});

   logic signed [45:0] cx_ff [CORDIC_STAGES+1];
   logic signed [45:0] cy_ff [CORDIC_STAGES+1];
   logic signed [32:0] cz_ff [CORDIC_STAGES+1];
   flag_type           cf_ff [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0] cv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (en) begin
         cv_ff <= {cv_ff[CORDIC_STAGES-1:0], side_v_ff[SQ_ROOT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]          <= $signed({6'b0, den});
         cy_ff[0]          <= 46'(num);
         cz_ff[0]          <= '0;
         cf_ff[0].term_neg <= side_last.term_neg;
         cf_ff[0].y_le0    <= side_last.y_le0;
         cf_ff[0].analytic <= side_last.analytic;
         cf_ff[0].den_zero <= (den == '0);
         cf_ff[0].tprod    <= dist_c * RAD_PER_DEG_Q30;
      end
   end

   // Vectoring CORDIC, one rotation per stage.
   for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[j] < 0) begin
               cx_ff[j+1] <= cx_ff[j] - (cy_ff[j] >>> j);
               cy_ff[j+1] <= cy_ff[j] + (cx_ff[j] >>> j);
               cz_ff[j+1] <= cz_ff[j] - atan_q30(j);
            end else begin
               cx_ff[j+1] <= cx_ff[j] + (cy_ff[j] >>> j);
               cy_ff[j+1] <= cy_ff[j] - (cx_ff[j] >>> j);
               cz_ff[j+1] <= cz_ff[j] + atan_q30(j);
            end
            cf_ff[j+1] <= cf_ff[j];
         end
      end
   end

   // Result selection: table, out of range, vertical, or the solved angle.
   flag_type           fin;
   logic signed [33:0] z_round;
   logic signed [33:0] z_ang;
   logic signed [33:0] z_clamp;
   logic [48:0]        t_round;
   logic [ANGLE_W-1:0] pitch_sel;
   status_type         status_sel;

   assign fin     = cf_ff[CORDIC_STAGES];
   assign z_round = 34'(cz_ff[CORDIC_STAGES]) + 34'sd8192;
   assign z_ang   = z_round >>> 14;
   assign z_clamp = (z_ang > PITCH_HALF_PI) ? PITCH_HALF_PI :
                    ((z_ang < -PITCH_HALF_PI) ? -PITCH_HALF_PI : z_ang);
   assign t_round = fin.tprod + (49'd1 << 29);

   always_comb begin
      if (!fin.analytic) begin
         pitch_sel  = t_round[47:30];
         status_sel = STATUS_SOLVED;
      end else if (fin.term_neg) begin
         pitch_sel  = PITCH_QUARTER_PI;
         status_sel = STATUS_RANGE;
      end else if (fin.den_zero) begin
         pitch_sel  = fin.y_le0 ? PITCH_HALF_PI[ANGLE_W-1:0] : ANGLE_W'(-PITCH_HALF_PI);
         status_sel = STATUS_VERTICAL;
      end else begin
         pitch_sel  = z_clamp[ANGLE_W-1:0];
         status_sel = STATUS_SOLVED;
      end
   end

   // Result register.
   logic [ANGLE_W-1:0] out_pitch_ff;
   status_type         out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= cv_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_pitch_ff  <= pitch_sel;
         out_status_ff <= status_sel;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.elev_angle   = $signed(out_pitch_ff);
   assign rsp_chan.solve_status = out_status_ff;

endmodule

`default_nettype wire
